// ===== rtl/core/route_request_count_table_macros.svh =====
// Assertion macros shared by the route request count table RTL.
// Included by the modules that carry concurrent checks; expects clk and arst_n in scope.
`ifndef ROUTE_REQUEST_COUNT_TABLE_MACROS_SVH
`define ROUTE_REQUEST_COUNT_TABLE_MACROS_SVH

`ifndef SYNTHESIS

// Property check clocked on clk, disabled while reset is asserted.
`define RRCT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Expression that must hold at every clock edge outside reset.
`define RRCT_INVARIANT(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);

`else

`define RRCT_ASSERT(label, prop, msg)
`define RRCT_INVARIANT(label, expr, msg)

`endif

`endif

// ===== rtl/core/rrct_pkg.sv =====
// Shared types and constants for the route request count table.
// No dependencies; imported by route_request_count_table.
`timescale 1ns / 1ps

package rrct_pkg;

	localparam int RRCT_DEPTH_DEFAULT = 64;
	localparam int RRCT_KIND_W        = 2;
	localparam int RRCT_KEY_W         = 32;
	localparam int RRCT_COUNT_W       = 16;
	localparam int RRCT_STAMP_W       = 32;
	localparam int RRCT_LIMIT_W       = 7;

	localparam logic [RRCT_LIMIT_W-1:0] RRCT_LIMIT_RESET = RRCT_LIMIT_W'(64);
	localparam logic [RRCT_COUNT_W-1:0] RRCT_COUNT_MAX   = '1;

	// Operation codes carried in the kind field.
	localparam logic [RRCT_KIND_W-1:0] KIND_UPDATE = 2'd0;
	localparam logic [RRCT_KIND_W-1:0] KIND_REMOVE = 2'd1;
	localparam logic [RRCT_KIND_W-1:0] KIND_QUERY  = 2'd2;

	// One stored table entry; the valid bit lives outside the memory.
	typedef struct packed {
		logic [RRCT_KEY_W-1:0]   key;
		logic [RRCT_COUNT_W-1:0] count;
		logic [RRCT_STAMP_W-1:0] stamp;
	} rrct_entry_t;

	localparam int RRCT_ENTRY_W = $bits(rrct_entry_t);

	// Fields of one result beat.
	typedef struct packed {
		logic                    hit;
		logic [RRCT_COUNT_W-1:0] count;
		logic                    evicted;
	} rrct_result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WRITE,
		ST_DONE
	} rrct_state_t;

endpackage

// ===== rtl/core/rrct_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing; used for the entry store of the route request count table.
`timescale 1ns / 1ps

module rrct_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/core/route_request_count_table.sv =====
// Route request count table: keyed per-destination counts with oldest-stamp eviction.
// One item at a time: an accepted item passes through a walk over the entry RAM, one entry
// per cycle, then a write-back state, then a result load state that waits while out_stall
// holds back a pending result; the result beat is offered from the output register.
// Reset: arst_n clears all valid bits, the occupancy count and the state at once;
// table_limit resets to 64. There is no clearing pass, so the block is ready right after reset.
`timescale 1ns / 1ps

`include "route_request_count_table_macros.svh"

module route_request_count_table
	import rrct_pkg::*;
#(
	parameter int TABLE_DEPTH = RRCT_DEPTH_DEFAULT
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// Input channel
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [RRCT_KIND_W-1:0]  kind,
	input  logic [RRCT_KEY_W-1:0]   dest_address,
	input  logic [RRCT_STAMP_W-1:0] now,
	// Result channel
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic                    hit,
	output logic [RRCT_COUNT_W-1:0] request_count,
	output logic                    evicted,
	// Configuration write channel
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [RRCT_LIMIT_W-1:0] cfg_data
);

	localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = AW + 1;
	localparam int OCC_W = $clog2(TABLE_DEPTH + 1);
	localparam int CMP_W = (OCC_W > RRCT_LIMIT_W) ? OCC_W : RRCT_LIMIT_W;

	rrct_state_t state_q, state_d;

	logic [RRCT_LIMIT_W-1:0] table_limit_q;
	logic [TABLE_DEPTH-1:0]  valid_q;
	logic [TABLE_DEPTH-1:0]  valid_d;
	logic [OCC_W-1:0]        occ_q;

	// Captured input item
	logic [RRCT_KIND_W-1:0]  kind_q;
	logic [RRCT_KEY_W-1:0]   key_q;
	logic [RRCT_STAMP_W-1:0] now_q;

	// Walk counter and the compare stage behind the RAM read
	logic [CNT_W-1:0] cnt_q;
	logic             cmp_en_s1;
	logic [AW-1:0]    cmp_idx_s1;
	logic             valid_s1;

	// Search results gathered over the walk
	logic                    match_found_q;
	logic [AW-1:0]           match_idx_q;
	logic [RRCT_COUNT_W-1:0] match_count_q;
	logic                    pick_found_q;
	logic [AW-1:0]           pick_idx_q;
	logic [RRCT_STAMP_W-1:0] pick_stamp_q;
	logic                    free_found_q;
	logic [AW-1:0]           free_idx_q;

	rrct_result_t res_q, res_d;
	logic         out_valid_q;

	// RAM interface
	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	rrct_entry_t   ram_wdata, ram_rdata;

	logic in_accept, scan_done, load_out;

	// Write-back decisions
	logic                    is_update, is_remove, is_query;
	logic [RRCT_LIMIT_W-1:0] eff_limit;
	logic                    full_c, do_evict, ins_ok;
	logic [AW-1:0]           ins_idx;
	logic [RRCT_COUNT_W-1:0] inc_count;

	rrct_ram #(
		.WIDTH(RRCT_ENTRY_W),
		.DEPTH(TABLE_DEPTH)
	) u_entry_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign in_accept = in_valid && !in_stall;
	assign scan_done = (cnt_q == CNT_W'(TABLE_DEPTH));
	assign cfg_ready = 1'b1;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_done) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Write-back decisions from the gathered search results
	always_comb begin
		is_update = (kind_q == KIND_UPDATE);
		is_remove = (kind_q == KIND_REMOVE);
		is_query  = (kind_q == KIND_QUERY);
		eff_limit = (table_limit_q == '0) ? RRCT_LIMIT_W'(1) : table_limit_q;
		full_c    = (occ_q == OCC_W'(TABLE_DEPTH)) || (CMP_W'(occ_q) >= CMP_W'(eff_limit));
		do_evict  = is_update && !match_found_q && full_c && pick_found_q;
		ins_ok    = do_evict || free_found_q;
		if (do_evict && !(free_found_q && (free_idx_q < pick_idx_q))) begin
			ins_idx = pick_idx_q;
		end else begin
			ins_idx = free_idx_q;
		end
		inc_count = (match_count_q == RRCT_COUNT_MAX) ? RRCT_COUNT_MAX
			: match_count_q + RRCT_COUNT_W'(1);

		res_d.hit     = match_found_q && (is_update || is_remove || is_query);
		res_d.evicted = do_evict;
		if (is_update && match_found_q) begin
			res_d.count = inc_count;
		end else if (is_update) begin
			res_d.count = RRCT_COUNT_W'(1);
		end else if (is_query && match_found_q) begin
			res_d.count = match_count_q;
		end else begin
			res_d.count = '0;
		end
	end

	// Next valid bits: an evicted slot may be refilled by the insert in the same cycle.
	always_comb begin
		valid_d = valid_q;
		if (state_q == ST_WRITE) begin
			if (is_update && !match_found_q) begin
				if (do_evict) begin
					valid_d[pick_idx_q] = 1'b0;
				end
				if (ins_ok) begin
					valid_d[ins_idx] = 1'b1;
				end
			end else if (is_remove && match_found_q) begin
				valid_d[match_idx_q] = 1'b0;
			end
		end
	end

	// State machine outputs: handshake, RAM access and result load
	always_comb begin
		in_stall  = (state_q != ST_IDLE);
		ram_re    = (state_q == ST_SCAN) && !scan_done;
		ram_raddr = cnt_q[AW-1:0];
		ram_we    = 1'b0;
		ram_waddr = match_idx_q;
		ram_wdata.key   = key_q;
		ram_wdata.stamp = now_q;
		ram_wdata.count = inc_count;
		load_out  = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
		if (state_q == ST_WRITE && is_update) begin
			if (match_found_q) begin
				ram_we = 1'b1;
			end else begin
				ram_we          = ins_ok;
				ram_waddr       = ins_idx;
				ram_wdata.count = RRCT_COUNT_W'(1);
			end
		end
	end

	// Control registers: state, configuration, valid bits, occupancy, walk counter, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			table_limit_q <= RRCT_LIMIT_RESET;
			valid_q       <= '0;
			occ_q         <= '0;
			out_valid_q   <= 1'b0;
			cnt_q         <= '0;
			cmp_en_s1     <= 1'b0;
		end else begin
			state_q <= state_d;
			valid_q <= valid_d;
			if (cfg_valid && cfg_ready) begin
				table_limit_q <= cfg_data;
			end
			if (in_accept) begin
				cnt_q <= '0;
			end else if (ram_re) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			cmp_en_s1 <= ram_re;
			if (state_q == ST_WRITE) begin
				if (is_update && !match_found_q) begin
					if (ins_ok && !do_evict) begin
						occ_q <= occ_q + OCC_W'(1);
					end
				end else if (is_remove && match_found_q) begin
					occ_q <= occ_q - OCC_W'(1);
				end
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Item capture and the search over the entries read back from the RAM
	always_ff @(posedge clk) begin
		cmp_idx_s1 <= ram_raddr;
		valid_s1   <= valid_q[ram_raddr];
		if (in_accept) begin
			kind_q        <= kind;
			key_q         <= dest_address;
			now_q         <= now;
			match_found_q <= 1'b0;
			pick_found_q  <= 1'b0;
			free_found_q  <= 1'b0;
		end else if (state_q == ST_SCAN && cmp_en_s1) begin
			if (valid_s1) begin
				if (!match_found_q && ram_rdata.key == key_q) begin
					match_found_q <= 1'b1;
					match_idx_q   <= cmp_idx_s1;
					match_count_q <= ram_rdata.count;
				end
				if (!pick_found_q || ram_rdata.stamp < pick_stamp_q) begin
					pick_found_q <= 1'b1;
					pick_idx_q   <= cmp_idx_s1;
					pick_stamp_q <= ram_rdata.stamp;
				end
			end else if (!free_found_q) begin
				free_found_q <= 1'b1;
				free_idx_q   <= cmp_idx_s1;
			end
		end
		if (state_q == ST_WRITE) begin
			res_q <= res_d;
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (load_out) begin
			hit           <= res_q.hit;
			request_count <= res_q.count;
			evicted       <= res_q.evicted;
		end
	end

	assign out_valid = out_valid_q;

	// Checks on occupancy bookkeeping and result sequencing
	`RRCT_INVARIANT(a_occ_matches_valid, $countones(valid_q) == occ_q, "occupancy mismatch")
	`RRCT_INVARIANT(a_occ_in_range, occ_q <= OCC_W'(TABLE_DEPTH), "occupancy above depth")
	`RRCT_ASSERT(a_out_after_done, $rose(out_valid) |-> $past(state_q == ST_DONE), "early result")
	`RRCT_ASSERT(a_evict_miss, (out_valid && evicted) |-> !hit, "eviction reported on a hit")
	`RRCT_ASSERT(a_evict_one, (out_valid && evicted) |-> (request_count == RRCT_COUNT_W'(1)), "count")

endmodule
